FILE: design/tlsfbbs_pkg.sv
`default_nettype none
package tlsfbbs_pkg;

    localparam int LEVEL_MAX  = 32;
    localparam int SUB_SHIFT  = 4;
    localparam int ALIGN_BITS = 3;

    localparam int SMALL_SHIFT = SUB_SHIFT + ALIGN_BITS;
    localparam int ROW_COUNT   = LEVEL_MAX - SMALL_SHIFT + 1;
    localparam int ROW_BINS    = 1 << SUB_SHIFT;

    localparam int OP_W    = 2;
    localparam int SIZE_W  = 31;
    localparam int RSIZE_W = 32;
    localparam int LOG_W   = $clog2(RSIZE_W);
    localparam int FL_W    = 5;
    localparam int FLX_W   = FL_W + 1;
    localparam int SL_W    = SUB_SHIFT;

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH   = 2'd0,
        OP_MARK_SET = 2'd1,
        OP_MARK_CLR = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef struct packed {
        logic [RSIZE_W-1:0] rounded;
        logic [FL_W-1:0]    fl;
        logic [SL_W-1:0]    sl;
        logic               err;
    } t_map;

    typedef struct packed {
        logic            found;
        logic [FL_W-1:0] fl;
        logic [SL_W-1:0] sl;
        logic            err;
    } t_res;

    function automatic logic [LOG_W-1:0] floor_log2(input logic [RSIZE_W-1:0] x);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < RSIZE_W; i++) begin
            if (x[i]) begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [SL_W-1:0] lowest_sl(input logic [ROW_BINS-1:0] x);
        logic [SL_W-1:0] r;
        r = '0;
        for (int i = ROW_BINS - 1; i >= 0; i--) begin
            if (x[i]) begin
                r = SL_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [FL_W-1:0] lowest_fl(input logic [ROW_COUNT-1:0] x);
        logic [FL_W-1:0] r;
        r = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--) begin
            if (x[i]) begin
                r = FL_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/tlsfbbs_map.sv
`default_nettype none
module tlsfbbs_map (
    input  wire logic [tlsfbbs_pkg::OP_W-1:0]   i_op,
    input  wire logic [tlsfbbs_pkg::SIZE_W-1:0] i_size,
    output tlsfbbs_pkg::t_map                   o_map
);
    import tlsfbbs_pkg::*;

    localparam logic [RSIZE_W-1:0] SMALL_LIMIT = RSIZE_W'(1) << SMALL_SHIFT;

    logic [RSIZE_W-1:0] size_ext;
    logic [LOG_W-1:0]   m_in;
    logic [RSIZE_W-1:0] rmask;
    logic [RSIZE_W-1:0] rsum;
    logic [RSIZE_W-1:0] rounded;
    logic [LOG_W-1:0]   m_out;
    logic [FLX_W-1:0]   fl_wide;
    logic [SL_W-1:0]    sl_big;

    always_comb begin
        size_ext = RSIZE_W'(i_size);
        m_in     = floor_log2(size_ext);
        rmask    = (RSIZE_W'(1) << (m_in - LOG_W'(SUB_SHIFT))) - RSIZE_W'(1);
        rsum     = size_ext + rmask;
        if (t_op'(i_op) == OP_SEARCH && size_ext >= SMALL_LIMIT) begin
            rounded = rsum & ~rmask;
        end else begin
            rounded = size_ext;
        end

        m_out   = floor_log2(rounded);
        sl_big  = SL_W'(rounded >> (m_out - LOG_W'(SUB_SHIFT)));
        fl_wide = FLX_W'(m_out) - FLX_W'(SMALL_SHIFT - 1);

        o_map.rounded = rounded;
        if (rounded < SMALL_LIMIT) begin
            o_map.fl  = '0;
            o_map.sl  = rounded[ALIGN_BITS +: SL_W];
            o_map.err = 1'b0;
        end else begin
            o_map.fl  = fl_wide[FL_W-1:0];
            o_map.sl  = sl_big;
            o_map.err = (fl_wide >= FLX_W'(ROW_COUNT));
        end
    end

endmodule
`default_nettype wire

FILE: design/tlsfbbs_bitmap.sv
`default_nettype none
module tlsfbbs_bitmap (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire logic [tlsfbbs_pkg::OP_W-1:0] i_op,
    input  tlsfbbs_pkg::t_map                 i_map,
    output tlsfbbs_pkg::t_res                 o_res
);
    import tlsfbbs_pkg::*;

    logic [ROW_COUNT-1:0] r_level;
    logic [ROW_BINS-1:0]  r_bins [ROW_COUNT];

    logic [ROW_BINS-1:0]  row_sel;
    logic [ROW_BINS-1:0]  row_hit;
    logic [ROW_BINS-1:0]  sl_bit;
    logic [ROW_BINS-1:0]  n_row;
    logic [ROW_COUNT-1:0] lv_hit;
    logic [ROW_COUNT-1:0] row_nz;
    logic [SL_W-1:0]      row_low [ROW_COUNT];
    logic [FL_W-1:0]      f_up;
    logic                 upd;

    always_comb begin
        for (int r = 0; r < ROW_COUNT; r++) begin
            row_nz[r]  = |r_bins[r];
            row_low[r] = lowest_sl(r_bins[r]);
        end
    end

    always_comb begin
        row_sel = i_map.err ? '0 : r_bins[i_map.fl];
        row_hit = row_sel & ({ROW_BINS{1'b1}} << i_map.sl);
        lv_hit  = r_level & ({ROW_COUNT{1'b1}} << (FLX_W'(i_map.fl) + FLX_W'(1)));
        f_up    = lowest_fl(lv_hit);
        sl_bit  = ROW_BINS'(1) << i_map.sl;
        n_row   = (t_op'(i_op) == OP_MARK_SET) ? (row_sel | sl_bit) : (row_sel & ~sl_bit);
        upd     = i_fire && !i_map.err
                  && (t_op'(i_op) == OP_MARK_SET || t_op'(i_op) == OP_MARK_CLR);
    end

    always_comb begin
        o_res.found = 1'b0;
        o_res.fl    = '0;
        o_res.sl    = '0;
        o_res.err   = 1'b0;
        unique case (t_op'(i_op))
            OP_SEARCH: begin
                o_res.err = i_map.err;
                if (!i_map.err) begin
                    o_res.fl = i_map.fl;
                    o_res.sl = i_map.sl;
                    if (|row_hit) begin
                        o_res.found = 1'b1;
                        o_res.sl    = lowest_sl(row_hit);
                    end else if ((|lv_hit) && row_nz[f_up]) begin
                        o_res.found = 1'b1;
                        o_res.fl    = f_up;
                        o_res.sl    = row_low[f_up];
                    end
                end
            end
            OP_MARK_SET, OP_MARK_CLR: begin
                o_res.err = i_map.err;
                if (!i_map.err) begin
                    o_res.found = 1'b1;
                    o_res.fl    = i_map.fl;
                    o_res.sl    = i_map.sl;
                end
            end
            OP_NONE: begin
                o_res.found = 1'b0;
            end
            default: begin
                o_res.found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_bins[r] <= '0;
            end
        end else if (upd) begin
            r_bins[i_map.fl]  <= n_row;
            r_level[i_map.fl] <= |n_row;
        end
    end

endmodule
`default_nettype wire

FILE: design/tlsf_bin_bitmap_search_top.sv
// TLSF bin bitmap unit: takes one word per cycle (search, mark nonempty, mark empty, no-op)
// while the input is not stalled and returns one result word per input word; each word is
// registered in the input register and then in the result register. An input register feeds a
// single combinational pass (size rounding, bin mapping, masked priority encoders over the
// 26-row by 16-bit bitmaps) into a result register; bitmap updates land in the same edge
// as the result, so the next word always sees them. The bitmaps clear in the reset cycle;
// no clearing pass is needed.
`default_nettype none
module tlsf_bin_bitmap_search_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [tlsfbbs_pkg::OP_W-1:0]    i_operation,
    input  wire logic [tlsfbbs_pkg::SIZE_W-1:0]  i_size,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_found,
    output logic [tlsfbbs_pkg::FL_W-1:0]         o_first_level,
    output logic [tlsfbbs_pkg::SL_W-1:0]         o_second_level,
    output logic [tlsfbbs_pkg::RSIZE_W-1:0]      o_rounded_size,
    output logic                                 o_range_error
);
    import tlsfbbs_pkg::*;

    logic               r_in_vld;
    logic [OP_W-1:0]    r_in_op;
    logic [SIZE_W-1:0]  r_in_size;
    logic               r_out_vld;
    t_res               r_res;
    logic [RSIZE_W-1:0] r_rounded;

    logic advance;
    logic fire;
    logic in_load;
    t_map map;
    t_res res;

    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;
    assign in_load    = !o_in_stall;

    tlsfbbs_map u_map (
        .i_op   (r_in_op),
        .i_size (r_in_size),
        .o_map  (map)
    );

    tlsfbbs_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_op    (r_in_op),
        .i_map   (map),
        .o_res   (res)
    );

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_load) begin
            r_in_vld <= i_in_valid;
        end
        if (in_load && i_in_valid) begin
            r_in_op   <= i_operation;
            r_in_size <= i_size;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
        if (fire) begin
            r_res     <= res;
            r_rounded <= map.rounded;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_found        = r_res.found;
    assign o_first_level  = r_res.fl;
    assign o_second_level = r_res.sl;
    assign o_rounded_size = r_rounded;
    assign o_range_error  = r_res.err;

endmodule
`default_nettype wire

FILE: design/tlsfbbs_checker.sv
`default_nettype none
module tlsfbbs_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic                            o_found,
    input wire logic [tlsfbbs_pkg::FL_W-1:0]    o_first_level,
    input wire logic [tlsfbbs_pkg::SL_W-1:0]    o_second_level,
    input wire logic [tlsfbbs_pkg::RSIZE_W-1:0] o_rounded_size,
    input wire logic                            o_range_error
);

    // a range error reports no bin
    a_err_no_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> !o_found && o_first_level == '0
                                         && o_second_level == '0)
        else $error("range error word carries a bin");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rounded_size)
                                       && $stable(o_found))
        else $error("stalled result word changed");

endmodule

bind tlsf_bin_bitmap_search_top tlsfbbs_checker u_tlsfbbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_found        (o_found),
    .o_first_level  (o_first_level),
    .o_second_level (o_second_level),
    .o_rounded_size (o_rounded_size),
    .o_range_error  (o_range_error)
);
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlsfbbs_pkg::*;

    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int DOG_LIMIT   = 5000;
    localparam int MARK_KEEP   = 64;
    localparam logic [63:0] SMALL_SIZE = 64'd1 << SMALL_SHIFT;

    typedef struct packed {
        t_op               op;
        logic [SIZE_W-1:0] size;
    } t_bin_req;

    typedef struct packed {
        logic               found;
        logic [FL_W-1:0]    fl;
        logic [SL_W-1:0]    sl;
        logic [RSIZE_W-1:0] rounded;
        logic               err;
    } t_bin_res;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_operation = '0;
    logic [SIZE_W-1:0]    i_size      = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_found;
    logic [FL_W-1:0]      o_first_level;
    logic [SL_W-1:0]      o_second_level;
    logic [RSIZE_W-1:0]   o_rounded_size;
    logic                 o_range_error;

    tlsf_bin_bitmap_search_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_size         (i_size),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_first_level  (o_first_level),
        .o_second_level (o_second_level),
        .o_rounded_size (o_rounded_size),
        .o_range_error  (o_range_error)
    );

    t_bin_req             pending_words[$];
    t_bin_res             expected_bins[$];
    logic [SIZE_W-1:0]    marked_sizes[$];
    logic [ROW_COUNT-1:0] lvl_map = '0;
    logic [ROW_BINS-1:0]  row_map [ROW_COUNT];
    int                 n_sent      = 0;
    int                 n_total     = 0;
    int                 n_errors    = 0;
    int                 in_gap      = 0;
    int                 out_gap     = 0;
    int                 idle_cycles = 0;
    logic               long_hold   = 1'b0;
    wire                calm = (n_sent + CALM_ITEMS >= n_total);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned msb_pos(input logic [63:0] x);
        int unsigned p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic int unsigned lsb_pos(input logic [63:0] x);
        int unsigned p;
        p = 0;
        for (int i = 63; i >= 0; i--) begin
            if (x[i]) begin
                p = i;
            end
        end
        return p;
    endfunction

    // bin lookup and bitmap update for one accepted word
    function automatic t_bin_res predict_bin(input t_op op, input logic [SIZE_W-1:0] sz);
        t_bin_res    r;
        logic [63:0] rs;
        logic [63:0] mask;
        logic [63:0] row;
        logic [63:0] lv;
        int unsigned m;
        int unsigned fl;
        int unsigned sl;
        int unsigned f;
        r = '0;
        rs = {33'd0, sz};
        if (op == OP_SEARCH && rs >= SMALL_SIZE) begin
            mask = (64'd1 << (msb_pos(rs) - SUB_SHIFT)) - 64'd1;
            rs = (rs + mask) & ~mask;
        end
        r.rounded = rs[RSIZE_W-1:0];
        if (op == OP_NONE) begin
            return r;
        end
        if (rs < SMALL_SIZE) begin
            fl = 0;
            sl = 32'((rs >> ALIGN_BITS) & 64'(ROW_BINS - 1));
        end else begin
            m  = msb_pos(rs);
            sl = 32'((rs >> (m - SUB_SHIFT)) & 64'(ROW_BINS - 1));
            fl = m - SMALL_SHIFT + 1;
        end
        if (fl >= ROW_COUNT) begin
            r.err = 1'b1;
            return r;
        end
        case (op)
            OP_SEARCH: begin
                row = 64'(row_map[fl]) & (~64'd0 << sl);
                if (row != 0) begin
                    r.found = 1'b1;
                    sl = lsb_pos(row);
                end else begin
                    lv = 64'(lvl_map) & (~64'd0 << (fl + 1));
                    if (lv != 0) begin
                        f = lsb_pos(lv);
                        if (f < ROW_COUNT && row_map[f] != 0) begin
                            r.found = 1'b1;
                            fl = f;
                            sl = lsb_pos(64'(row_map[f]));
                        end
                    end
                end
            end
            OP_MARK_SET: begin
                r.found = 1'b1;
                row_map[fl][sl] = 1'b1;
                lvl_map[fl] = 1'b1;
            end
            default: begin
                r.found = 1'b1;
                row_map[fl][sl] = 1'b0;
                if (row_map[fl] == 0) begin
                    lvl_map[fl] = 1'b0;
                end
            end
        endcase
        r.fl = fl[FL_W-1:0];
        r.sl = sl[SL_W-1:0];
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned       e;
        logic [SIZE_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = SIZE_W'($urandom);
            1: s = $urandom_range(0, 1) ? '0 : '1;
            default: begin
                e = $urandom_range(0, SIZE_W - 1);
                s = SIZE_W'($urandom) & ((SIZE_W'(1) << e) - SIZE_W'(1));
                s = s | (SIZE_W'(1) << e);
                if ($urandom_range(0, 3) != 0) begin
                    s[ALIGN_BITS-1:0] = '0;
                end
            end
        endcase
        return s;
    endfunction

    task automatic add_word(input t_op op, input logic [SIZE_W-1:0] s);
        t_bin_req w;
        w.op = op;
        w.size = s;
        pending_words.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    initial begin
        for (int i = 0; i < ROW_COUNT; i++) begin
            row_map[i] = '0;
        end
    end

    // sender
    always @(posedge i_clk) begin : drive_p
        t_bin_req w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                expected_bins.push_back(predict_bin(t_op'(i_operation), i_size));
                n_sent++;
            end
            if (in_gap != 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !calm && !long_hold &&
                         $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(1, 19) - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= w.op;
                i_size      <= w.size;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_gap != 0) begin
                out_gap--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 19);
            end
            i_out_stall <= long_hold || (out_gap != 0);
        end
    end

    // long output hold so the block backs up into its input
    initial begin
        wait (n_sent >= 400);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin : watch_p
        t_bin_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bins.size() == 0) begin
                $display("%0t unexpected result word: expected none actual %0h %0h %0h %0h %0h",
                         $time, o_found, o_first_level, o_second_level, o_rounded_size,
                         o_range_error);
                n_errors++;
            end else begin
                e = expected_bins.pop_front();
                check_field("found", 32'(e.found), 32'(o_found));
                check_field("first_level", 32'(e.fl), 32'(o_first_level));
                check_field("second_level", 32'(e.sl), 32'(o_second_level));
                check_field("rounded_size", e.rounded, o_rounded_size);
                check_field("range_error", 32'(e.err), 32'(o_range_error));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= DOG_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stim_p
        int                r;
        int unsigned       k;
        logic [SIZE_W-1:0] s;

        add_word(OP_SEARCH, '0);
        add_word(OP_SEARCH, 31'h7FFFFFFF);
        add_word(OP_MARK_SET, '0);
        add_word(OP_SEARCH, '0);
        add_word(OP_SEARCH, 31'd8);
        add_word(OP_MARK_SET, 31'h7FFFFFFF);
        add_word(OP_SEARCH, 31'd8);
        add_word(OP_SEARCH, 31'h7FFFFFFF);
        add_word(OP_SEARCH, 31'h7C000000);
        add_word(OP_MARK_SET, 31'd127);
        add_word(OP_MARK_SET, 31'd135);
        add_word(OP_SEARCH, 31'd129);
        add_word(OP_SEARCH, 31'd120);
        add_word(OP_MARK_SET, '0);
        add_word(OP_MARK_CLR, '0);
        add_word(OP_MARK_CLR, '0);
        add_word(OP_NONE, 31'h7FFFFFFF);
        add_word(OP_NONE, '0);
        add_word(OP_MARK_CLR, 31'h7FFFFFFF);
        add_word(OP_MARK_CLR, 31'd127);
        add_word(OP_SEARCH, 31'h55555555);
        add_word(OP_MARK_CLR, 31'd135);
        add_word(OP_SEARCH, 31'h2AAAAAAA);
        add_word(OP_MARK_SET, 31'h40000000);
        add_word(OP_SEARCH, 31'h3FFFFFF9);

        for (int i = 0; i < 1600; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_word(OP_SEARCH, pick_size());
            end else if (r < 65) begin
                s = pick_size();
                if (marked_sizes.size() < MARK_KEEP) begin
                    marked_sizes.push_back(s);
                end else begin
                    marked_sizes[$urandom_range(0, MARK_KEEP - 1)] = s;
                end
                add_word(OP_MARK_SET, s);
            end else if (r < 92) begin
                if (marked_sizes.size() > 0 && $urandom_range(0, 3) != 0) begin
                    k = $urandom_range(0, marked_sizes.size() - 1);
                    s = marked_sizes[k];
                    marked_sizes.delete(k);
                end else begin
                    s = pick_size();
                end
                add_word(OP_MARK_CLR, s);
            end else begin
                add_word(OP_NONE, pick_size());
            end
        end
        n_total = pending_words.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_sent != n_total || expected_bins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
